// ----- rtl/core/sgr_pkg.sv -----
// Shared constants for the stream group reverser.
package sgr_pkg;

  localparam int VALUE_W      = 32;
  localparam int GROUP_SIZE_W = 5;

  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = GROUP_SIZE_W'(4);

endpackage

// ----- rtl/core/stream_group_reverser.sv -----
// Stream group reverser: collects values into groups and emits each group reversed.
//
// Input stream (s_axis_*): one signed 32-bit value per beat in tdata, tlast marks
// the final element of a list. Output stream (m_axis_*): one value per beat,
// tlast marks the last value of an emitted run, tuser marks the last value of a list.
// Configuration channel (cfg_*): writes group_size (1..MAX_GROUP; 0 acts as 1,
// larger values saturate to MAX_GROUP). Write it only while the block is idle.
//
// A beat that neither completes a group nor ends a list is only buffered and
// produces nothing. A beat that completes a group (emitted reversed) or ends a
// list with a short group (emitted in arrival order) starts a drain of its n
// buffered values: each value is read from the buffer into a registered read
// result and then loaded into the output register, and the next read is not
// issued until that load is done. The block returns to idle once the last
// value is loaded. The input is held off while a drain runs; the last value
// may still wait in the output register while the next input beat is taken.
// A stalled receiver holds the drain; no value is lost or repeated.
// Reset empties the group and sets group_size to 4; the buffer needs no clearing.
module stream_group_reverser #(
  parameter int MAX_GROUP = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sgr_pkg::GROUP_SIZE_W-1:0] cfg_data,   // [4:0] group_size
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sgr_pkg::VALUE_W-1:0] s_axis_tdata,    // [31:0] value
  input  logic                        s_axis_tlast,    // list_end
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sgr_pkg::VALUE_W-1:0] m_axis_tdata,    // [31:0] out_value
  output logic                        m_axis_tlast,    // run_last
  output logic                        m_axis_tuser     // [0] list_done
);

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CMP_W  = (CNT_W > sgr_pkg::GROUP_SIZE_W) ? CNT_W : sgr_pkg::GROUP_SIZE_W;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t                            state;
  logic [sgr_pkg::GROUP_SIZE_W-1:0]  group_size;
  logic [CNT_W-1:0]                  fill;
  logic [CNT_W-1:0]                  run_len;
  logic [CNT_W-1:0]                  rd_cnt;
  logic                              rev;
  logic                              list_end;
  logic                              rd_pend;
  logic                              rd_last;
  logic                              rd_done;

  logic                              in_beat;
  logic [CNT_W-1:0]                  n_in;
  logic [CMP_W-1:0]                  size_raw;
  logic [CMP_W-1:0]                  size_eff;
  logic                              group_full;
  logic                              rd_en;
  logic                              rd_is_last;
  logic [CNT_W-1:0]                  rd_pos;
  logic [sgr_pkg::VALUE_W-1:0]       rd_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign n_in          = fill + CNT_W'(1);

  always_comb begin
    size_raw = CMP_W'(group_size);
    size_eff = size_raw;
    if (size_raw == '0) begin
      size_eff = CMP_W'(1);
    end else if (size_raw > CMP_W'(MAX_GROUP)) begin
      size_eff = CMP_W'(MAX_GROUP);
    end
  end

  assign group_full = CMP_W'(n_in) >= size_eff;

  // issue a read only when the output register is free by the time data lands
  assign rd_en      = (state == ST_DRAIN) && (rd_cnt != run_len) && !rd_pend &&
                      (!m_axis_tvalid || m_axis_tready);
  assign rd_is_last = (rd_cnt == run_len - CNT_W'(1));
  assign rd_pos     = rev ? (run_len - CNT_W'(1) - rd_cnt) : rd_cnt;

  sgr_buffer #(
    .DEPTH  (MAX_GROUP),
    .ADDR_W (ADDR_W)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (in_beat),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_pos[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      group_size    <= sgr_pkg::GROUP_SIZE_RESET;
      fill          <= '0;
      run_len       <= '0;
      rd_cnt        <= '0;
      rev           <= 1'b0;
      list_end      <= 1'b0;
      rd_pend       <= 1'b0;
      rd_last       <= 1'b0;
      rd_done       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        group_size <= cfg_data;
      end

      // drop the beat once taken, then load a pending read over it
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (rd_pend) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= rd_data;
        m_axis_tlast  <= rd_last;
        m_axis_tuser  <= rd_done;
      end

      rd_pend <= rd_en;

      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (group_full || s_axis_tlast) begin
              state    <= ST_DRAIN;
              run_len  <= n_in;
              rd_cnt   <= '0;
              rev      <= group_full;
              list_end <= s_axis_tlast;
              fill     <= '0;
            end else begin
              fill <= n_in;
            end
          end
        end
        ST_DRAIN: begin
          if (rd_en) begin
            rd_cnt  <= rd_cnt + CNT_W'(1);
            rd_last <= rd_is_last;
            rd_done <= rd_is_last && list_end;
          end
          if ((rd_cnt == run_len) && !rd_pend) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a read in flight always lands in the output register on the next edge
  assert property (@(posedge clk) disable iff (rst) rd_pend |=> m_axis_tvalid)
    else $error("read data not loaded into output register");

  // no input is taken while a buffer read is still in flight
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !rd_pend)
    else $error("input accepted during drain");

  // the fill level between groups never reaches the buffer depth
  assert property (@(posedge clk) disable iff (rst) fill < CNT_W'(MAX_GROUP))
    else $error("group buffer overfilled");

  // a drain never reads past the run it was started for
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_DRAIN) |-> (rd_cnt <= run_len) && (run_len != '0))
    else $error("drain counter out of range");

  // the final value of a list is always the final value of its run
  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("list end without run end");

endmodule

// ----- rtl/core/sgr_buffer.sv -----
// Group buffer: one write port, one read port with registered read data.
module sgr_buffer #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [sgr_pkg::VALUE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [sgr_pkg::VALUE_W-1:0] rd_data
);

  logic [sgr_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the stream group reverser: directed table, then random lists.
`timescale 1ns / 100ps

module tb_top;

  localparam int          VALUE_W      = sgr_pkg::VALUE_W;
  localparam int          GROUP_SIZE_W = sgr_pkg::GROUP_SIZE_W;
  localparam int          MAX_GROUP    = 16;
  localparam int          DRAIN_SETTLE = 2 * MAX_GROUP + 8;
  localparam int          LONG_HOLD    = 300;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BEATS  = 17;
  localparam int          MAX_PRINTS   = 60;
  localparam int          N_ROWS       = 29;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               run_last;
    logic               list_done;
  } reorder_beat_t;

  typedef enum logic [1:0] {ROW_SIZE, ROW_BEAT, ROW_BEAT_EXP} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [VALUE_W-1:0] data;
    logic               last;
    reorder_beat_t      want;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [GROUP_SIZE_W-1:0] cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [VALUE_W-1:0]      s_axis_tdata = '0;   // [31:0] value
  logic                    s_axis_tlast = 1'b0; // list_end
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]      m_axis_tdata;        // [31:0] out_value
  logic                    m_axis_tlast;        // run_last
  logic                    m_axis_tuser;        // [0] list_done

  // Predictor state
  logic [VALUE_W-1:0]      held_vals [MAX_GROUP];
  int unsigned             held_cnt = 0;
  logic [GROUP_SIZE_W-1:0] size_reg = sgr_pkg::GROUP_SIZE_RESET;
  reorder_beat_t           step_out [$];
  reorder_beat_t           pending_beats [$];

  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  bit                      send_calm = 1'b0;
  bit                      recv_calm = 1'b0;
  bit                      hold_request = 1'b0;

  localparam logic [GROUP_SIZE_W-1:0] FIXED_SIZES [5] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2};

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_BEAT,     32'h0000_0001, 1'b0, '0},
    '{ROW_BEAT,     32'h8000_0000, 1'b0, '0},
    '{ROW_BEAT,     32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_BEAT,     32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_BEAT_EXP, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
    '{ROW_BEAT,     32'hA5A5_A5A5, 1'b0, '0},
    '{ROW_BEAT,     32'h5A5A_5A5A, 1'b1, '0},
    '{ROW_BEAT,     32'h0000_0011, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0022, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0033, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0044, 1'b1, '0},
    '{ROW_SIZE,     32'd1,         1'b0, '0},
    '{ROW_BEAT_EXP, 32'h7FFF_FFFF, 1'b0, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{ROW_BEAT_EXP, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
    '{ROW_SIZE,     32'd0,         1'b0, '0},
    '{ROW_BEAT_EXP, 32'h1234_5678, 1'b0, '{32'h1234_5678, 1'b1, 1'b0}},
    '{ROW_BEAT_EXP, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
    '{ROW_SIZE,     32'd8,         1'b0, '0},
    '{ROW_BEAT,     32'h0000_0101, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0202, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0303, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0404, 1'b0, '0},
    '{ROW_BEAT,     32'h0000_0505, 1'b0, '0},
    // shrink below the fill level: the next beat flushes all six reversed
    '{ROW_SIZE,     32'd3,         1'b0, '0},
    '{ROW_BEAT,     32'h0000_0606, 1'b0, '0},
    '{ROW_SIZE,     32'd17,        1'b0, '0},
    '{ROW_BEAT,     32'hDEAD_BEEF, 1'b0, '0},
    '{ROW_BEAT,     32'h0BAD_F00D, 1'b0, '0},
    '{ROW_BEAT,     32'hC001_CAFE, 1'b1, '0}
  };

  stream_group_reverser #(
    .MAX_GROUP(MAX_GROUP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk = ~clk;

  function automatic int unsigned effective_group(input logic [GROUP_SIZE_W-1:0] sz);
    int unsigned s;
    s = int'(sz);
    if (s == 0) s = 1;
    if (s > MAX_GROUP) s = MAX_GROUP;
    return s;
  endfunction

  // Compute the beats one input value releases into step_out.
  function automatic void reorder_step(input logic [VALUE_W-1:0] v, input logic end_flag);
    int unsigned eff;
    int unsigned n;
    step_out.delete();
    eff = effective_group(size_reg);
    if (held_cnt < MAX_GROUP) begin
      held_vals[held_cnt] = v;
      held_cnt++;
    end
    n = held_cnt;
    if (n >= eff) begin
      for (int unsigned k = 0; k < n; k++)
        step_out.push_back('{held_vals[n-1-k], k == n - 1, end_flag && (k == n - 1)});
      held_cnt = 0;
    end else if (end_flag) begin
      for (int unsigned k = 0; k < n; k++)
        step_out.push_back('{held_vals[k], k == n - 1, k == n - 1});
      held_cnt = 0;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic load_group_size(input logic [GROUP_SIZE_W-1:0] sz);
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = sz;
  endtask

  task automatic push_beat(input logic [VALUE_W-1:0] v, input logic end_flag,
                           input bit typed, input reorder_beat_t want);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= end_flag;
    do @(posedge clk); while (!s_axis_tready);
    reorder_step(v, end_flag);
    if (typed) pending_beats.push_back(want);
    else foreach (step_out[i]) pending_beats.push_back(step_out[i]);
  endtask

  task automatic run_phase(input logic [GROUP_SIZE_W-1:0] sz, input bit long_hold);
    int unsigned eff;
    int unsigned left_in_list;
    logic [VALUE_W-1:0] v;
    load_group_size(sz);
    send_calm    = ($urandom_range(0, 3) == 0);
    recv_calm    = ($urandom_range(0, 3) == 0);
    hold_request = long_hold;
    eff = effective_group(sz);
    left_in_list = 0;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      if (left_in_list == 0) begin
        case ($urandom_range(0, 3))
          0:       left_in_list = eff;
          1:       left_in_list = 2 * eff;
          default: left_in_list = $urandom_range(1, 2 * eff + 2);
        endcase
      end
      case ($urandom_range(0, 7))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      left_in_list--;
      // a list cut off at the phase end leaves a partial group for the next size
      push_beat(v, left_in_list == 0, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_SIZE:     load_group_size(directed_rows[r].data[GROUP_SIZE_W-1:0]);
        ROW_BEAT:     push_beat(directed_rows[r].data, directed_rows[r].last, 1'b0, '0);
        ROW_BEAT_EXP: push_beat(directed_rows[r].data, directed_rows[r].last, 1'b1,
                                directed_rows[r].want);
        default:      ;
      endcase
    end
    for (int p = 0; p < PHASES; p++)
      run_phase((p < 5) ? FIXED_SIZES[p] : GROUP_SIZE_W'($urandom_range(0, 31)),
                (p == 1) || (p == 5));
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : drain_side
    int unsigned pause;
    while (rst) @(posedge clk);
    forever begin
      // hold off for a long stretch when asked, so the input backs up
      if (hold_request) begin
        pause = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        pause = recv_calm ? 0 : $urandom_range(0, 4);
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin : check_out
    reorder_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat tdata=%h", m_axis_tdata));
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata !== want.value)
          flag_mismatch($sformatf("tdata %h, want %h", m_axis_tdata, want.value));
        if (m_axis_tlast !== want.run_last)
          flag_mismatch($sformatf("tlast %b, want %b (tdata %h)",
                                  m_axis_tlast, want.run_last, want.value));
        if (m_axis_tuser !== want.list_done)
          flag_mismatch($sformatf("tuser %b, want %b (tdata %h)",
                                  m_axis_tuser, want.list_done, want.value));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, pending_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
